// ----- sv/vted_pkg.sv -----
// Shared types and constants for the VT52 escape decoder.
// Used by vted_step, vted_store, the top level and the testbench; no other dependencies.
package vted_pkg;

	typedef enum logic [1:0] {
		ST_NORMAL = 2'd0,
		ST_ESC    = 2'd1,
		ST_ROW    = 2'd2,
		ST_COL    = 2'd3
	} pstate_t;

	typedef enum logic [3:0] {
		ACT_NONE    = 4'd0,
		ACT_PUT     = 4'd1,
		ACT_NEWLINE = 4'd2,
		ACT_MOVE    = 4'd3,
		ACT_BELL    = 4'd4,
		ACT_ERASE   = 4'd5,
		ACT_CLREOL  = 4'd6,
		ACT_CLRBOT  = 4'd7,
		ACT_DELLN   = 4'd8,
		ACT_INSCH   = 4'd9,
		ACT_INSLN   = 4'd10,
		ACT_SOON    = 4'd11,
		ACT_SOOFF   = 4'd12
	} action_t;

	localparam logic [6:0] CH_BEL   = 7'h07;
	localparam logic [6:0] CH_BS    = 7'h08;
	localparam logic [6:0] CH_LF    = 7'h0a;
	localparam logic [6:0] CH_ESC   = 7'h1b;
	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_TILDE = 7'h7e;
	localparam logic [6:0] CH_UP    = 7'h41;
	localparam logic [6:0] CH_DOWN  = 7'h42;
	localparam logic [6:0] CH_RIGHT = 7'h43;
	localparam logic [6:0] CH_LEFT  = 7'h44;
	localparam logic [6:0] CH_ERASE = 7'h4a;
	localparam logic [6:0] CH_EOL   = 7'h4b;
	localparam logic [6:0] CH_BOT   = 7'h4c;
	localparam logic [6:0] CH_DELLN = 7'h4e;
	localparam logic [6:0] CH_INSCH = 7'h4f;
	localparam logic [6:0] CH_INSLN = 7'h50;
	localparam logic [6:0] CH_ADDR  = 7'h59;
	localparam logic [6:0] CH_SOON  = 7'h61;
	localparam logic [6:0] CH_SOOFF = 7'h62;

	localparam logic [6:0] ROWS_RESET = 7'd24;
	localparam logic [7:0] COLS_RESET = 8'd80;
	localparam logic [6:0] ROWS_MAX   = 7'd64;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	// One display's context as held in the state memory.
	typedef struct packed {
		pstate_t    pstate;
		logic [6:0] pend_row;
		logic [5:0] cur_row;
		logic [7:0] cur_col;
	} entry_t;

	typedef struct packed {
		action_t    action;
		logic [5:0] at_row;
		logic [7:0] at_col;
		logic [6:0] glyph;
		logic       scrolled;
	} res_t;

endpackage

// ----- sv/vted_step.sv -----
// Per-character update of one display context: parser, cursor and command.
// Depends on vted_pkg.
module vted_step
	import vted_pkg::*;
(
	input  entry_t     cur,
	input  logic [6:0] ch,
	input  logic [6:0] rows,
	input  logic [7:0] cols,
	output entry_t     nxt,
	output res_t       res
);

	logic [6:0] rows_m1;
	logic [7:0] cols_m1;
	logic [5:0] y;
	logic [7:0] x;
	logic [5:0] ty;
	logic [7:0] tx;
	logic       y_last;
	logic       x_last;
	logic [6:0] ch_off;
	action_t    act;
	logic [6:0] g;
	logic       sc;

	always_comb begin
		rows_m1 = rows - 7'd1;
		cols_m1 = cols - 8'd1;
		// A cursor left outside a shrunk screen is pulled to the last row and column.
		y = ({1'b0, cur.cur_row} > rows_m1) ? rows_m1[5:0] : cur.cur_row;
		x = (cur.cur_col > cols_m1) ? cols_m1 : cur.cur_col;
		y_last = ({1'b0, y} + 7'd1) >= rows;
		x_last = ({1'b0, x} + 9'd1) >= {1'b0, cols};
		ch_off = ch - CH_SPACE;

		nxt = cur;
		ty  = y;
		tx  = x;
		act = ACT_NONE;
		g   = '0;
		sc  = 1'b0;

		case (cur.pstate)
			ST_NORMAL: begin
				if (ch inside {[CH_SPACE:CH_TILDE]}) begin
					act = ACT_PUT;
					g   = ch;
					if (x_last) begin
						tx = '0;
						if (y_last) sc = 1'b1;
						else ty = y + 6'd1;
					end else begin
						tx = x + 8'd1;
					end
				end else if (ch == CH_LF) begin
					act = ACT_NEWLINE;
					tx  = '0;
					if (y_last) sc = 1'b1;
					else ty = y + 6'd1;
				end else if (ch == CH_BS) begin
					if (x != '0) begin
						act = ACT_MOVE;
						tx  = x - 8'd1;
					end
				end else if (ch == CH_BEL) begin
					act = ACT_BELL;
				end else if (ch == CH_ESC) begin
					nxt.pstate = ST_ESC;
				end
			end
			ST_ESC: begin
				nxt.pstate = ST_NORMAL;
				case (ch)
					CH_UP: begin
						if (y != '0) begin
							act = ACT_MOVE;
							ty  = y - 6'd1;
						end
					end
					CH_DOWN: begin
						if (!y_last) begin
							act = ACT_MOVE;
							ty  = y + 6'd1;
						end
					end
					CH_RIGHT: begin
						if (!x_last) begin
							act = ACT_MOVE;
							tx  = x + 8'd1;
						end
					end
					CH_LEFT: begin
						if (x != '0) begin
							act = ACT_MOVE;
							tx  = x - 8'd1;
						end
					end
					CH_ADDR:  nxt.pstate = ST_ROW;
					CH_ERASE: begin
						act = ACT_ERASE;
						ty  = '0;
						tx  = '0;
					end
					CH_EOL:   act = ACT_CLREOL;
					CH_BOT:   act = ACT_CLRBOT;
					CH_DELLN: act = ACT_DELLN;
					CH_INSCH: act = ACT_INSCH;
					CH_INSLN: act = ACT_INSLN;
					CH_SOON:  act = ACT_SOON;
					CH_SOOFF: act = ACT_SOOFF;
					default:  act = ACT_NONE;
				endcase
			end
			ST_ROW: begin
				nxt.pstate   = ST_COL;
				nxt.pend_row = ch_off;
			end
			default: begin
				nxt.pstate = ST_NORMAL;
				// Addresses off the screen are dropped without moving the cursor.
				if (ch >= CH_SPACE && cur.pend_row < rows && {1'b0, ch_off} < cols) begin
					act = ACT_MOVE;
					ty  = cur.pend_row[5:0];
					tx  = {1'b0, ch_off};
				end
			end
		endcase

		nxt.cur_row = ty;
		nxt.cur_col = tx;

		res.action   = act;
		res.glyph    = g;
		res.scrolled = sc;
		if (act == ACT_MOVE) begin
			res.at_row = ty;
			res.at_col = tx;
		end else begin
			res.at_row = y;
			res.at_col = x;
		end
	end

endmodule

// ----- sv/vted_store.sv -----
// Context memory for all displays: synchronous RAM with a registered read,
// per-entry valid bits for reset, and a bypass for a write-then-read overlap.
// Depends on vted_pkg.
module vted_store
	import vted_pkg::*;
#(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	output entry_t        rd_data
);

	entry_t             mem [DEPTH];
	entry_t             mem_rd_q;
	logic [DEPTH-1:0]   vld_q;
	logic               vld_rd_q;
	logic               byp_hit_q;
	entry_t             byp_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) mem_rd_q <= mem[rd_addr];
		if (rd_en) byp_data_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			vld_rd_q  <= 1'b0;
			byp_hit_q <= 1'b0;
		end else begin
			if (wr_en) vld_q[wr_addr] <= 1'b1;
			// The read sees the old word when the same entry is written at that edge,
			// so the written word is kept aside for the reader.
			if (rd_en) begin
				vld_rd_q  <= vld_q[rd_addr];
				byp_hit_q <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	assign rd_data = byp_hit_q ? byp_data_q : (vld_rd_q ? mem_rd_q : '0);

	a_byp_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en && wr_addr == rd_addr) |=> byp_hit_q)
		else $error("bypass not taken for same-entry overlap");
	a_vld_set: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> vld_q[$past(wr_addr)])
		else $error("valid bit not set after write");
	a_byp_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |=> byp_data_q == $past(wr_data))
		else $error("bypass word not captured");

endmodule

// ----- sv/vt52_escape_terminal_decoder.sv -----
// Channel  Dir  Payload                                         Accepted when
// s_       in   tdata: display[2:0] char_in[10:3]               s_tvalid & s_tready
// m_       out  tdata: display/row/col/glyph/scrolled, tuser    m_tvalid & m_tready
// cfg_     in   cfg_index (0 rows, 1 cols), cfg_data            cfg_valid & cfg_ready
//
// One character per cycle sustained while the output is not stalled; a result is offered
// after its transaction: the RAM read and the step fill stage one, then the output register loads.
// The RAM read-modify-write loop is closed by a bypass, so characters for the
// same display may follow back to back. Reset restores 24 rows by 80 columns
// and marks every display context as cleared. A stalled output holds stage one;
// input is still taken while stage one is empty or moving on.
module vt52_escape_terminal_decoder
	import vted_pkg::*;
#(
	parameter int DISPLAYS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // display[2:0], char_in[10:3], zero[15:11]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // display_out[2:0], at_row[8:3], at_col[16:9],
	                               // glyph[23:17], scrolled[24], zero[31:25]
	output logic [3:0]  m_tuser,   // action[3:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int AW = (DISPLAYS > 1) ? $clog2(DISPLAYS) : 1;

	logic [6:0] rows_q;
	logic [7:0] cols_q;
	logic [6:0] rows_eff;
	logic [7:0] cols_eff;

	logic       s1_valid_q;
	logic [2:0] s1_disp_q;
	logic [6:0] s1_ch_q;
	logic       out_valid_q;
	logic [2:0] out_disp_q;
	res_t       out_res_q;

	logic       in_acc;
	logic       s1_adv;
	logic       s1_in_range;
	logic       wr_en;
	entry_t     cur_ctx;
	entry_t     nxt_ctx;
	res_t       step_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_ROWS) rows_q <= cfg_data[6:0];
			else cols_q <= cfg_data;
		end
	end

	always_comb begin
		if (rows_q == '0) rows_eff = 7'd1;
		else if (rows_q > ROWS_MAX) rows_eff = ROWS_MAX;
		else rows_eff = rows_q;
		cols_eff = (cols_q == '0) ? 8'd1 : cols_q;
	end

	assign s1_adv      = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready    = !s1_valid_q || s1_adv;
	assign in_acc      = s_tvalid && s_tready;
	assign s1_in_range = int'(s1_disp_q) < DISPLAYS;
	assign wr_en       = s1_adv && s1_in_range;

	vted_store #(
		.DEPTH (DISPLAYS),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rd_addr (AW'(s_tdata[2:0])),
		.wr_en   (wr_en),
		.wr_addr (AW'(s1_disp_q)),
		.wr_data (nxt_ctx),
		.rd_data (cur_ctx)
	);

	vted_step u_step (
		.cur  (cur_ctx),
		.ch   (s1_ch_q),
		.rows (rows_eff),
		.cols (cols_eff),
		.nxt  (nxt_ctx),
		.res  (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) s1_valid_q <= s_tvalid;
			if (s1_adv) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_disp_q <= s_tdata[2:0];
			s1_ch_q   <= s_tdata[9:3];
		end
		if (s1_adv) begin
			out_disp_q <= s1_disp_q;
			// A display beyond the configured count is ignored with an empty command.
			if (s1_in_range) out_res_q <= step_res;
			else out_res_q <= '{action: ACT_NONE, default: '0};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_res_q.action;
	assign m_tdata  = {7'd0, out_res_q.scrolled, out_res_q.glyph, out_res_q.at_col,
		out_res_q.at_row, out_disp_q};

	a_wr_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> s1_valid_q)
		else $error("context write without an item in stage one");
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input taken while stage one is blocked");
	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> m_tvalid)
		else $error("advanced item did not reach the output register");
	a_scroll_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[24]) |-> (m_tuser == ACT_PUT || m_tuser == ACT_NEWLINE))
		else $error("scroll flagged on a command that cannot scroll");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for vt52_escape_terminal_decoder.
// Needs vted_pkg and the decoder RTL; per-display cursor and parser state are
// predicted here and every result transaction is compared in order.
module testbench;
	import vted_pkg::*;

	typedef struct {
		logic [2:0] disp;
		action_t    act;
		logic [5:0] row;
		logic [7:0] col;
		logic [6:0] glyph;
		logic       scrolled;
	} screen_cmd_t;

	typedef struct packed {
		logic [2:0] d;
		logic [7:0] c;
		logic       typed;
		action_t    act;
		logic [5:0] row;
		logic [7:0] col;
		logic [6:0] glyph;
		logic       sc;
	} script_row_t;

	typedef enum {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PATTERN} rx_mode_t;

	localparam int PHASES = 7;
	localparam int RANDOM_PHASE = 5;
	localparam int ITEMS_PER_PHASE = 180;
	localparam int LONG_HOLD = 300;

	localparam logic [6:0] ESC_LETTERS [12] = '{CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT,
		CH_ERASE, CH_EOL, CH_BOT, CH_DELLN, CH_INSCH, CH_INSLN, CH_SOON, CH_SOOFF};

	// Screen sizes per phase: large first so that the shrink afterwards clamps cursors.
	localparam logic [7:0] PHASE_ROWS [PHASES] = '{8'hff, 8'd5, 8'd1, 8'd0, 8'd64, 8'd0, 8'd24};
	localparam logic [7:0] PHASE_COLS [PHASES] = '{8'hff, 8'd12, 8'd1, 8'd0, 8'd3, 8'd0, 8'd80};

	// Directed opening at the reset size of 24 by 80.
	localparam script_row_t SCRIPT [32] = '{
		'{3'd0, 8'h41,            1'b1, ACT_PUT,     6'd0,  8'd0,  7'h41, 1'b0},
		'{3'd0, {1'b0, CH_BS},    1'b1, ACT_MOVE,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd0, {1'b0, CH_BS},    1'b1, ACT_NONE,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd0, {1'b0, CH_BEL},   1'b1, ACT_BELL,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd0, {1'b0, CH_ESC},   1'b1, ACT_NONE,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd0, {1'b0, CH_ERASE}, 1'b1, ACT_ERASE,   6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd1, 8'hda,            1'b1, ACT_PUT,     6'd0,  8'd0,  7'h5a, 1'b0},
		'{3'd7, 8'hff,            1'b1, ACT_NONE,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd2, {1'b0, CH_ESC},   1'b0, ACT_NONE,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd2, {1'b0, CH_ADDR},  1'b0, ACT_NONE,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd2, 8'h37,            1'b0, ACT_NONE,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd2, 8'h6f,            1'b1, ACT_MOVE,    6'd23, 8'd79, 7'h00, 1'b0},
		'{3'd2, 8'h78,            1'b1, ACT_PUT,     6'd23, 8'd79, 7'h78, 1'b1},
		'{3'd2, {1'b0, CH_LF},    1'b1, ACT_NEWLINE, 6'd23, 8'd0,  7'h00, 1'b1},
		'{3'd3, {1'b0, CH_ESC},   1'b0, ACT_NONE,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd3, {1'b0, CH_ADDR},  1'b0, ACT_NONE,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd3, 8'h38,            1'b0, ACT_NONE,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd3, 8'h20,            1'b1, ACT_NONE,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd2, {1'b0, CH_ESC},   1'b0, ACT_NONE,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd2, {1'b0, CH_EOL},   1'b1, ACT_CLREOL,  6'd23, 8'd0,  7'h00, 1'b0},
		'{3'd2, {1'b0, CH_ESC},   1'b0, ACT_NONE,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd2, {1'b0, CH_BOT},   1'b1, ACT_CLRBOT,  6'd23, 8'd0,  7'h00, 1'b0},
		'{3'd2, {1'b0, CH_ESC},   1'b0, ACT_NONE,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd2, {1'b0, CH_DELLN}, 1'b1, ACT_DELLN,   6'd23, 8'd0,  7'h00, 1'b0},
		'{3'd2, {1'b0, CH_ESC},   1'b0, ACT_NONE,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd2, {1'b0, CH_INSCH}, 1'b1, ACT_INSCH,   6'd23, 8'd0,  7'h00, 1'b0},
		'{3'd2, {1'b0, CH_ESC},   1'b0, ACT_NONE,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd2, {1'b0, CH_INSLN}, 1'b1, ACT_INSLN,   6'd23, 8'd0,  7'h00, 1'b0},
		'{3'd2, {1'b0, CH_ESC},   1'b0, ACT_NONE,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd2, {1'b0, CH_SOON},  1'b1, ACT_SOON,    6'd23, 8'd0,  7'h00, 1'b0},
		'{3'd2, {1'b0, CH_ESC},   1'b0, ACT_NONE,    6'd0,  8'd0,  7'h00, 1'b0},
		'{3'd2, {1'b0, CH_SOOFF}, 1'b1, ACT_SOOFF,   6'd23, 8'd0,  7'h00, 1'b0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_ROWS;
	logic [7:0]  cfg_data = '0;

	// Predicted display contexts and screen size.
	pstate_t    parse_st [8];
	logic [6:0] row_latch [8];
	logic [5:0] cur_row [8];
	logic [7:0] cur_col [8];
	logic [6:0] rows_setting;
	logic [7:0] cols_setting;

	screen_cmd_t expected_cmds [$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          burst_left = 0;
	bit          tx_gappy = 1'b1;
	rx_mode_t    rx_mode = RX_ALWAYS;
	int          hold_pending = 0;
	int          hold_served = 0;

	vt52_escape_terminal_decoder #(.DISPLAYS(8)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int unsigned eff_rows();
		if (rows_setting == 7'd0)
			return 1;
		if (rows_setting > ROWS_MAX)
			return 32'(ROWS_MAX);
		return 32'(rows_setting);
	endfunction

	function automatic int unsigned eff_cols();
		return (cols_setting == 8'd0) ? 1 : 32'(cols_setting);
	endfunction

	// Advances one display's parser and cursor by one byte and returns its command.
	function automatic screen_cmd_t advance_display(input logic [2:0] d, input logic [7:0] b);
		logic [6:0]  ch;
		int unsigned rows, cols, y, x, ty, tx;
		action_t     act;
		logic [6:0]  g;
		logic        sc;
		screen_cmd_t cmd;
		ch = b[6:0];
		act = ACT_NONE;
		g = '0;
		sc = 1'b0;
		rows = eff_rows();
		cols = eff_cols();
		y = 32'(cur_row[d]);
		x = 32'(cur_col[d]);
		// A cursor left outside a shrunk screen is pinned to the last cell.
		if (y >= rows)
			y = rows - 1;
		if (x >= cols)
			x = cols - 1;
		ty = y;
		tx = x;
		case (parse_st[d])
			ST_NORMAL: begin
				if (ch >= CH_SPACE && ch <= CH_TILDE) begin
					act = ACT_PUT;
					g = ch;
					tx = x + 1;
					if (tx >= cols) begin
						tx = 0;
						if (y + 1 >= rows)
							sc = 1'b1;
						else
							ty = y + 1;
					end
				end else if (ch == CH_LF) begin
					act = ACT_NEWLINE;
					tx = 0;
					if (y + 1 >= rows)
						sc = 1'b1;
					else
						ty = y + 1;
				end else if (ch == CH_BS) begin
					if (x != 0) begin
						act = ACT_MOVE;
						tx = x - 1;
					end
				end else if (ch == CH_BEL) begin
					act = ACT_BELL;
				end else if (ch == CH_ESC) begin
					parse_st[d] = ST_ESC;
				end
			end
			ST_ESC: begin
				parse_st[d] = ST_NORMAL;
				case (ch)
					CH_UP: if (y != 0) begin
						act = ACT_MOVE;
						ty = y - 1;
					end
					CH_DOWN: if (y + 1 < rows) begin
						act = ACT_MOVE;
						ty = y + 1;
					end
					CH_RIGHT: if (x + 1 < cols) begin
						act = ACT_MOVE;
						tx = x + 1;
					end
					CH_LEFT: if (x != 0) begin
						act = ACT_MOVE;
						tx = x - 1;
					end
					CH_ADDR: parse_st[d] = ST_ROW;
					CH_ERASE: begin
						act = ACT_ERASE;
						ty = 0;
						tx = 0;
					end
					CH_EOL: act = ACT_CLREOL;
					CH_BOT: act = ACT_CLRBOT;
					CH_DELLN: act = ACT_DELLN;
					CH_INSCH: act = ACT_INSCH;
					CH_INSLN: act = ACT_INSLN;
					CH_SOON: act = ACT_SOON;
					CH_SOOFF: act = ACT_SOOFF;
					default: ;
				endcase
			end
			ST_ROW: begin
				parse_st[d] = ST_COL;
				row_latch[d] = ch - CH_SPACE;
			end
			default: begin
				parse_st[d] = ST_NORMAL;
				if (ch >= CH_SPACE && row_latch[d] < rows && int'(ch) - 32 < int'(cols)) begin
					act = ACT_MOVE;
					ty = 32'(row_latch[d]);
					tx = 32'(ch - CH_SPACE);
				end
			end
		endcase
		cur_row[d] = ty[5:0];
		cur_col[d] = tx[7:0];
		cmd.disp = d;
		cmd.act = act;
		if (act == ACT_MOVE) begin
			cmd.row = ty[5:0];
			cmd.col = tx[7:0];
			cmd.glyph = '0;
			cmd.scrolled = 1'b0;
		end else begin
			cmd.row = y[5:0];
			cmd.col = x[7:0];
			cmd.glyph = g;
			cmd.scrolled = sc;
		end
		return cmd;
	endfunction

	// Bit 7 of a received byte is ignored, so it is set now and then.
	function automatic logic [7:0] on_wire(input logic [6:0] c);
		return {($urandom_range(0, 3) == 0), c};
	endfunction

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	task automatic send_char(input logic [2:0] d, input logic [7:0] c);
		int gap;
		gap = 0;
		if (tx_gappy && burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
			burst_left = $urandom_range(1, 24);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		s_tdata <= {5'd0, c, d};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		expected_cmds.push_back(advance_display(d, c));
		items_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_cmds.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_ROWS)
			rows_setting = val[6:0];
		else
			cols_setting = val;
		@(posedge clk);
	endtask

	// One well-formed sequence with random content, or now and then a broken one or noise.
	task automatic play_sequence();
		logic [2:0]  d;
		int          kind, n;
		int unsigned rows_now, cols_now;
		d = ($urandom_range(0, 2) != 0) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
		rows_now = eff_rows();
		cols_now = (eff_cols() > 95) ? 95 : eff_cols();
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			n = $urandom_range(1, 8);
			repeat (n) send_char(d, on_wire(7'($urandom_range(32, 126))));
		end else if (kind < 40) begin
			send_char(d, on_wire(CH_LF));
		end else if (kind < 47) begin
			send_char(d, on_wire(CH_BS));
		end else if (kind < 50) begin
			send_char(d, on_wire(CH_BEL));
		end else if (kind < 72) begin
			send_char(d, on_wire(CH_ESC));
			if ($urandom_range(0, 9) == 0)
				send_char(d, on_wire(7'($urandom_range(0, 127))));
			else
				send_char(d, on_wire(ESC_LETTERS[$urandom_range(0, 11)]));
		end else if (kind < 88) begin
			send_char(d, on_wire(CH_ESC));
			send_char(d, on_wire(CH_ADDR));
			if ($urandom_range(0, 9) == 0)
				send_char(d, on_wire(7'($urandom_range(0, 127))));
			else
				send_char(d, on_wire(7'(32 + $urandom_range(0, rows_now))));
			if ($urandom_range(0, 9) == 0)
				send_char(d, on_wire(7'($urandom_range(0, 127))));
			else
				send_char(d, on_wire(7'(32 + $urandom_range(0, cols_now))));
		end else if (kind < 94) begin
			// Sequence cut short; the next one on this display lands mid-parse.
			n = $urandom_range(1, 3);
			send_char(d, on_wire(CH_ESC));
			if (n >= 2)
				send_char(d, on_wire(CH_ADDR));
			if (n >= 3)
				send_char(d, on_wire(7'($urandom_range(0, 127))));
		end else begin
			send_char(d, 8'($urandom_range(0, 255)));
		end
	endtask

	// Receiver: stall pattern per phase, plus an occasional long hold-off.
	initial begin
		int          hold_count;
		logic [10:0] pat;
		hold_count = 0;
		pat = 11'b10110111001;
		forever begin
			@(posedge clk);
			if (hold_served != hold_pending) begin
				hold_served = hold_pending;
				hold_count = LONG_HOLD;
			end
			if (hold_count > 0) begin
				hold_count--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS: m_tready <= 1'b1;
					RX_COIN: m_tready <= 1'($urandom_range(0, 1));
					RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
					default: begin
						m_tready <= pat[0];
						pat = {pat[0], pat[10:1]};
					end
				endcase
			end
		end
	end

	// Every result transaction is checked against the oldest prediction.
	always @(posedge clk) begin
		screen_cmd_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.disp = m_tdata[2:0];
			got.act = action_t'(m_tuser);
			got.row = m_tdata[8:3];
			got.col = m_tdata[16:9];
			got.glyph = m_tdata[23:17];
			got.scrolled = m_tdata[24];
			if (expected_cmds.size() == 0) begin
				note_failure($sformatf("unexpected result: display %0d action %0d",
					got.disp, got.act));
			end else begin
				want = expected_cmds.pop_front();
				if (got.disp !== want.disp || got.act !== want.act || got.row !== want.row
						|| got.col !== want.col || got.glyph !== want.glyph
						|| got.scrolled !== want.scrolled)
					note_failure($sformatf({"mismatch (exp/got): display %0d/%0d action %0d/%0d",
						" row %0d/%0d col %0d/%0d glyph %0h/%0h scrolled %0d/%0d"},
						want.disp, got.disp, want.act, got.act, want.row, got.row,
						want.col, got.col, want.glyph, got.glyph,
						want.scrolled, got.scrolled));
			end
		end
	end

	initial begin
		#(12 * 400000);
		$display("FAIL");
		$finish;
	end

	initial begin
		int         p, w;
		int         phase_start;
		logic [7:0] rv, cv;
		rows_setting = ROWS_RESET;
		cols_setting = COLS_RESET;
		for (int i = 0; i < 8; i++) begin
			parse_st[i] = ST_NORMAL;
			row_latch[i] = '0;
			cur_row[i] = '0;
			cur_col[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rx_mode = RX_MOSTLY;
		for (int i = 0; i < 32; i++) begin
			send_char(SCRIPT[i].d, SCRIPT[i].c);
			if (SCRIPT[i].typed)
				expected_cmds[expected_cmds.size() - 1] = '{SCRIPT[i].d, SCRIPT[i].act,
					SCRIPT[i].row, SCRIPT[i].col, SCRIPT[i].glyph, SCRIPT[i].sc};
		end

		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			rv = PHASE_ROWS[p];
			cv = PHASE_COLS[p];
			if (p == RANDOM_PHASE) begin
				rv = 8'($urandom_range(0, 255));
				cv = 8'($urandom_range(0, 255));
			end
			write_reg(REG_ROWS, rv);
			write_reg(REG_COLS, cv);
			rx_mode = rx_mode_t'(p % 4);
			tx_gappy = (p % 3 != 1);
			// Hold the output off while the input keeps offering, so the pipe fills.
			if (p == 1 || p == 4) begin
				tx_gappy = 1'b0;
				hold_pending++;
			end
			phase_start = items_sent;
			while (items_sent - phase_start < ITEMS_PER_PHASE)
				play_sequence();
		end

		s_tvalid <= 1'b0;
		for (w = 0; w < 20000 && expected_cmds.size() != 0; w++)
			@(posedge clk);
		if (expected_cmds.size() != 0)
			note_failure($sformatf("%0d results never arrived", expected_cmds.size()));
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
